@@ hw/rtl/tfba_pkg.sv @@
package tfba_pkg;

  localparam int unsigned DefBlocks    = 256;
  localparam logic [8:0]  HotCountRst  = 9'd51;
  localparam logic [8:0]  WarmCountRst = 9'd76;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_REINIT = 2'd3;

  localparam logic [1:0] POOL_HOT  = 2'd0;
  localparam logic [1:0] POOL_WARM = 2'd1;
  localparam logic [1:0] POOL_COLD = 2'd2;
  localparam logic [1:0] POOL_NONE = 2'd3;

  localparam logic       CFG_HOT  = 1'b0;
  localparam logic       CFG_WARM = 1'b1;

  typedef struct packed {
    logic [1:0]  tag;
    logic [1:0]  hot;
    logic [15:0] key;
    logic [31:0] order;
    logic [15:0] erase;
    logic [3:0]  owner;
    logic        mapping;
  } entry_t;

  // Pool tried at a given rank of the fallback chain for a requested pool.
  function automatic logic [1:0] fallback(input logic [1:0] req, input logic [1:0] rank);
    logic [1:0] p;
    p = POOL_NONE;
    case (req)
      POOL_HOT:  p = (rank == 2'd0) ? POOL_HOT  : (rank == 2'd1) ? POOL_WARM : POOL_COLD;
      POOL_WARM: p = (rank == 2'd0) ? POOL_WARM : (rank == 2'd1) ? POOL_HOT  : POOL_COLD;
      POOL_COLD: p = (rank == 2'd0) ? POOL_COLD : (rank == 2'd1) ? POOL_WARM : POOL_HOT;
      default:   p = POOL_NONE;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/tfba_mem.sv @@
module tfba_mem #(
  parameter int unsigned BLOCKS = tfba_pkg::DefBlocks,
  parameter int unsigned AW     = $clog2(BLOCKS)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tfba_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output tfba_pkg::entry_t rd_data
);

  tfba_pkg::entry_t mem [BLOCKS];
  tfba_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/tiered_free_block_allocator_top.sv @@
// Free block pool allocator for one flash plane, with hot, warm and cold pools.
// Input channel in_*: one operation word (allocate, free, erase, reinit).
// Output channel out_*: exactly one result word per operation.
// Configuration channel cfg_*: writes the hot and warm seed counts; always ready.
// Every block's pool entry sits in one single-port-per-direction memory.
// Allocate reads all BLOCKS entries once, one per cycle, keeping the best
// candidate of each pool, then reads and writes back the winner, if any,
// before the result is posted. Free and erase do one read-modify-write
// before the result is posted. Free and erase that do nothing skip it and
// answer directly. Reinit and reset run a seeding pass that writes one entry
// per cycle over all BLOCKS entries; no operation is taken during it
// (configuration writes are). Reinit answers once the pass is done.
// One operation is in flight at a time; the next word is taken once the
// previous result sits in the output register, even if not yet taken.
// A stalled receiver holds the result; the block then waits before it can
// post the following result. Reset loads seed counts 51 and 76 and seeds.
module tiered_free_block_allocator_top #(
  parameter int unsigned BLOCKS = tfba_pkg::DefBlocks
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], block_id[9:2], hotness[11:10], wear_keyed[12], stream_sel[16:13],
  // for_mapping[17], zero fill above
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // granted_block[7:0], found[8], source_rank[10:9], retagged[11],
  // free_total[20:12], zero fill above
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int unsigned AW   = $clog2(BLOCKS);
  localparam int unsigned CW   = $clog2(BLOCKS + 1);
  localparam int unsigned IW   = (AW > 8) ? AW + 1 : 9;
  localparam int unsigned SW   = (AW + 1 > 10) ? AW + 2 : 11;

  localparam logic [2:0] S_SEED = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [8:0]    hc_r, hc_nxt, wc_r, wc_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          reinit_r, reinit_nxt;
  logic          rvld_r, rvld_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [31:0]   stamp_r, stamp_nxt;

  logic [1:0]    op_r, op_nxt, hotq_r, hotq_nxt;
  logic          wear_r, wear_nxt, map_r, map_nxt;
  logic [3:0]    strm_r, strm_nxt;

  logic          bv_r [3];
  logic          bv_nxt [3];
  logic [15:0]   bk_r [3];
  logic [15:0]   bk_nxt [3];
  logic [31:0]   bo_r [3];
  logic [31:0]   bo_nxt [3];
  logic [AW-1:0] bi_r [3];
  logic [AW-1:0] bi_nxt [3];

  logic [7:0]    res_blk_r, res_blk_nxt;
  logic          res_found_r, res_found_nxt;
  logic [1:0]    res_rank_r, res_rank_nxt;
  logic          res_retag_r, res_retag_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [23:0]   out_data_r, out_data_nxt;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  tfba_pkg::entry_t mem_wdata, mem_rdata, seed_e, wr_e;

  logic          in_acc;
  logic [IW-1:0] blk_ext;
  logic          blk_ok;
  logic [1:0]    seed_h;
  logic [9:0]    hw_sum;
  logic [1:0]    pick_pool;
  logic          pick_hit;
  logic [1:0]    pick_rank;
  logic [1:0]    scan_pool;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign blk_ext = IW'(in_tdata[9:2]);
  assign blk_ok  = (blk_ext < IW'(BLOCKS));
  assign hw_sum  = {1'b0, hc_r} + {1'b0, wc_r};

  always_comb begin
    if (SW'(cnt_r) < SW'(hc_r)) begin
      seed_h = tfba_pkg::POOL_HOT;
    end else if (SW'(cnt_r) < SW'(hw_sum)) begin
      seed_h = tfba_pkg::POOL_WARM;
    end else begin
      seed_h = tfba_pkg::POOL_COLD;
    end
    seed_e         = '0;
    seed_e.tag     = seed_h;
    seed_e.hot     = seed_h;
    seed_e.order   = 32'(cnt_r);
  end

  // First non-empty pool along the fallback chain.
  always_comb begin
    pick_hit  = 1'b0;
    pick_rank = 2'd0;
    pick_pool = tfba_pkg::POOL_NONE;
    for (int r = 2; r >= 0; r--) begin
      if (hotq_r != tfba_pkg::POOL_NONE && bv_r[tfba_pkg::fallback(hotq_r, 2'(r))]) begin
        pick_hit  = 1'b1;
        pick_rank = 2'(r);
        pick_pool = tfba_pkg::fallback(hotq_r, 2'(r));
      end
    end
  end

  assign scan_pool = mem_rdata.tag;

  always_comb begin
    wr_e = mem_rdata;
    res_retag_nxt = res_retag_r;
    free_nxt = free_r;
    stamp_nxt = stamp_r;
    case (op_r)
      tfba_pkg::OP_ALLOC: begin
        wr_e.tag     = tfba_pkg::POOL_NONE;
        wr_e.owner   = strm_r;
        wr_e.mapping = map_r;
        // The read data holds the granted entry only in the write-back cycle.
        if (state_r == S_WR && res_rank_r != 2'd0 && mem_rdata.hot != hotq_r) begin
          wr_e.hot      = hotq_r;
          res_retag_nxt = 1'b1;
        end
      end
      tfba_pkg::OP_FREE: begin
        wr_e.tag   = hotq_r;
        wr_e.key   = wear_r ? mem_rdata.erase : 16'd0;
        wr_e.order = stamp_r;
      end
      tfba_pkg::OP_ERASE: begin
        if (mem_rdata.erase != 16'hFFFF) begin
          wr_e.erase = mem_rdata.erase + 16'd1;
        end
        wr_e.owner   = 4'd0;
        wr_e.mapping = 1'b0;
      end
      default: wr_e = mem_rdata;
    endcase
    if (state_r == S_WR) begin
      if (op_r == tfba_pkg::OP_ALLOC) begin
        free_nxt = free_r - CW'(1);
      end else if (op_r == tfba_pkg::OP_FREE) begin
        stamp_nxt = stamp_r + 32'd1;
        if (mem_rdata.tag == tfba_pkg::POOL_NONE) begin
          free_nxt = free_r + CW'(1);
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hc_nxt        = hc_r;
    wc_nxt        = wc_r;
    cnt_nxt       = cnt_r;
    reinit_nxt    = reinit_r;
    rvld_nxt      = 1'b0;
    raddr_nxt     = raddr_r;
    tgt_nxt       = tgt_r;
    op_nxt        = op_r;
    hotq_nxt      = hotq_r;
    wear_nxt      = wear_r;
    map_nxt       = map_r;
    strm_nxt      = strm_r;
    res_blk_nxt   = res_blk_r;
    res_found_nxt = res_found_r;
    res_rank_nxt  = res_rank_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = seed_e;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r[AW-1:0];
    for (int p = 0; p < 3; p++) begin
      bv_nxt[p] = bv_r[p];
      bk_nxt[p] = bk_r[p];
      bo_nxt[p] = bo_r[p];
      bi_nxt[p] = bi_r[p];
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == tfba_pkg::CFG_HOT) begin
        hc_nxt = cfg_data;
      end else begin
        wc_nxt = cfg_data;
      end
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_SEED: begin
        mem_we = 1'b1;
        if (cnt_r == (AW+1)'(BLOCKS - 1)) begin
          state_nxt = reinit_r ? S_DONE : S_IDLE;
        end
        cnt_nxt = cnt_r + (AW+1)'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_tdata[1:0];
          hotq_nxt      = in_tdata[11:10];
          wear_nxt      = in_tdata[12];
          strm_nxt      = in_tdata[16:13];
          map_nxt       = in_tdata[17];
          tgt_nxt       = AW'(in_tdata[9:2]);
          res_blk_nxt   = 8'd0;
          res_found_nxt = 1'b0;
          res_rank_nxt  = 2'd0;
          cnt_nxt       = '0;
          reinit_nxt    = 1'b0;
          case (in_tdata[1:0])
            tfba_pkg::OP_ALLOC: begin
              state_nxt = S_SCAN;
              for (int p = 0; p < 3; p++) begin
                bv_nxt[p] = 1'b0;
              end
            end
            tfba_pkg::OP_FREE: begin
              state_nxt = (blk_ok && in_tdata[11:10] != tfba_pkg::POOL_NONE) ? S_RD : S_DONE;
            end
            tfba_pkg::OP_ERASE: state_nxt = blk_ok ? S_RD : S_DONE;
            default: begin
              state_nxt  = S_SEED;
              reinit_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r != (AW+1)'(BLOCKS)) begin
          mem_re    = 1'b1;
          rvld_nxt  = 1'b1;
          raddr_nxt = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + (AW+1)'(1);
        end else if (!rvld_r) begin
          state_nxt = S_PICK;
        end
        if (rvld_r && scan_pool != tfba_pkg::POOL_NONE) begin
          if (!bv_r[scan_pool] || mem_rdata.key < bk_r[scan_pool] ||
              (mem_rdata.key == bk_r[scan_pool] && mem_rdata.order < bo_r[scan_pool])) begin
            bv_nxt[scan_pool] = 1'b1;
            bk_nxt[scan_pool] = mem_rdata.key;
            bo_nxt[scan_pool] = mem_rdata.order;
            bi_nxt[scan_pool] = raddr_r;
          end
        end
      end
      S_PICK: begin
        if (pick_hit) begin
          tgt_nxt       = bi_r[pick_pool];
          res_blk_nxt   = 8'(bi_r[pick_pool]);
          res_found_nxt = 1'b1;
          res_rank_nxt  = pick_rank;
          state_nxt     = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = tgt_r;
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r;
        mem_wdata = wr_e;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, 9'(free_r), res_retag_r, res_rank_r, res_found_r,
                           res_blk_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SEED;
      hc_r        <= tfba_pkg::HotCountRst;
      wc_r        <= tfba_pkg::WarmCountRst;
      cnt_r       <= '0;
      reinit_r    <= 1'b0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      free_r      <= CW'(BLOCKS);
      stamp_r     <= 32'(BLOCKS);
      res_retag_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hc_r        <= hc_nxt;
      wc_r        <= wc_nxt;
      cnt_r       <= cnt_nxt;
      reinit_r    <= reinit_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_SEED) begin
        free_r  <= CW'(BLOCKS);
        stamp_r <= 32'(BLOCKS);
      end else begin
        free_r  <= free_nxt;
        stamp_r <= stamp_nxt;
      end
      if (in_acc) begin
        res_retag_r <= 1'b0;
      end else begin
        res_retag_r <= res_retag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r     <= raddr_nxt;
    tgt_r       <= tgt_nxt;
    op_r        <= op_nxt;
    hotq_r      <= hotq_nxt;
    wear_r      <= wear_nxt;
    map_r       <= map_nxt;
    strm_r      <= strm_nxt;
    res_blk_r   <= res_blk_nxt;
    res_found_r <= res_found_nxt;
    res_rank_r  <= res_rank_nxt;
    out_data_r  <= out_data_nxt;
    for (int p = 0; p < 3; p++) begin
      bv_r[p] <= bv_nxt[p];
      bk_r[p] <= bk_nxt[p];
      bo_r[p] <= bo_nxt[p];
      bi_r[p] <= bi_nxt[p];
    end
  end

  tfba_mem #(
    .BLOCKS (BLOCKS),
    .AW     (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(BLOCKS))
    else $error("free count above block count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second operation taken while one is in flight");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SEED || state_r == S_WR))
    else $error("memory written outside seeding or write-back");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and written in one cycle");

  a_grant_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[8]) |-> (out_data_r[11:0] == 12'd0))
    else $error("grant fields set without a found block");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int NBLK = 256;
  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // opcode[1:0], block_id[9:2], hotness[11:10], wear_keyed[12], stream_sel[16:13],
  // for_mapping[17], zero fill above
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // granted_block[7:0], found[8], source_rank[10:9], retagged[11],
  // free_total[20:12], zero fill above
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [8:0]  cfg_data;

  tiered_free_block_allocator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic       mapping;
    logic [3:0] stream;
    logic       wear;
    logic [1:0] hot;
    logic [7:0] blk;
    logic [1:0] op;
  } op_word_t;

  typedef struct packed {
    logic [8:0] total;
    logic       retag;
    logic [1:0] rank;
    logic       found;
    logic [7:0] blk;
  } grant_t;

  // Shadow state of the allocator.
  logic [1:0]  m_tag   [NBLK];
  logic [1:0]  m_hot   [NBLK];
  logic [15:0] m_key   [NBLK];
  logic [31:0] m_stamp [NBLK];
  logic [15:0] m_erase [NBLK];
  logic [3:0]  m_owner [NBLK];
  logic        m_map   [NBLK];
  logic [31:0] m_next_stamp;
  logic [8:0]  hot_cnt, warm_cnt;

  grant_t pending_grants[$];
  int mismatches, grants_seen, words_sent, allocs_found, fallbacks, retags;
  int idle_cycles;
  int rx_wait;
  bit hold_off;

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic void seed_pools();
    for (int b = 0; b < NBLK; b++) begin
      logic [1:0] h;
      if (b < hot_cnt) h = tfba_pkg::POOL_HOT;
      else if (b < hot_cnt + warm_cnt) h = tfba_pkg::POOL_WARM;
      else h = tfba_pkg::POOL_COLD;
      m_tag[b] = h; m_hot[b] = h; m_key[b] = '0; m_stamp[b] = b;
      m_erase[b] = '0; m_owner[b] = '0; m_map[b] = 1'b0;
    end
    m_next_stamp = NBLK;
  endfunction

  function automatic int best_in_pool(logic [1:0] pool);
    int best;
    best = -1;
    for (int b = 0; b < NBLK; b++) begin
      if (m_tag[b] != pool) continue;
      if (best < 0 || m_key[b] < m_key[best] ||
          (m_key[b] == m_key[best] && m_stamp[b] < m_stamp[best]))
        best = b;
    end
    return best;
  endfunction

  function automatic grant_t apply_op(op_word_t w);
    grant_t g;
    int b;
    logic [1:0] pool;
    g = '0;
    case (w.op)
      tfba_pkg::OP_ALLOC: begin
        if (w.hot != tfba_pkg::POOL_NONE) begin
          for (int r = 0; r < 3; r++) begin
            case (w.hot)
              tfba_pkg::POOL_HOT:
                pool = (r == 0) ? tfba_pkg::POOL_HOT :
                       (r == 1) ? tfba_pkg::POOL_WARM : tfba_pkg::POOL_COLD;
              tfba_pkg::POOL_WARM:
                pool = (r == 0) ? tfba_pkg::POOL_WARM :
                       (r == 1) ? tfba_pkg::POOL_HOT : tfba_pkg::POOL_COLD;
              default:
                pool = (r == 0) ? tfba_pkg::POOL_COLD :
                       (r == 1) ? tfba_pkg::POOL_WARM : tfba_pkg::POOL_HOT;
            endcase
            b = best_in_pool(pool);
            if (b >= 0) begin
              m_tag[b] = tfba_pkg::POOL_NONE;
              if (r > 0 && m_hot[b] != w.hot) begin
                m_hot[b] = w.hot;
                g.retag = 1'b1;
              end
              m_owner[b] = w.stream;
              m_map[b] = w.mapping;
              g.blk = b[7:0]; g.found = 1'b1; g.rank = r[1:0];
              break;
            end
          end
        end
      end
      tfba_pkg::OP_FREE: begin
        if (w.hot != tfba_pkg::POOL_NONE) begin
          m_tag[w.blk] = w.hot;
          m_key[w.blk] = w.wear ? m_erase[w.blk] : 16'd0;
          m_stamp[w.blk] = m_next_stamp;
          m_next_stamp = m_next_stamp + 32'd1;
        end
      end
      tfba_pkg::OP_ERASE: begin
        if (m_erase[w.blk] != 16'hFFFF) m_erase[w.blk] = m_erase[w.blk] + 16'd1;
        m_owner[w.blk] = '0;
        m_map[w.blk] = 1'b0;
      end
      default: seed_pools();
    endcase
    for (int i = 0; i < NBLK; i++) if (m_tag[i] != tfba_pkg::POOL_NONE) g.total++;
    return g;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // The valid line stays up into the next word when no gap is drawn.
  task automatic send_word(op_word_t w);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      wait_cycles(gap);
    end
    in_tdata  <= {6'd0, w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_grants.push_back(apply_op(w));
    words_sent++;
  endtask

  // Directed row checked in full, where expected value is obvious.
  task automatic send_checked(op_word_t w, grant_t exp_g);
    grant_t g;
    send_word(w);
    g = pending_grants[$];
    if (g !== exp_g) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: table %h predictor %h", exp_g, g);
    end
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == tfba_pkg::CFG_HOT) hot_cnt = val; else warm_cnt = val;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    wait_cycles(NBLK + 20);
  endtask

  // Receiver with random stalls; a long hold-off is requested by the sender.
  always @(posedge clk) begin
    grant_t got, exp_g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[20:0];
        grants_seen++;
        if (pending_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_g = pending_grants.pop_front();
          if (got !== exp_g) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp blk %0d found %0d rank %0d retag %0d total %0d",
                        " / got blk %0d found %0d rank %0d retag %0d total %0d"},
                       exp_g.blk, exp_g.found, exp_g.rank, exp_g.retag, exp_g.total,
                       got.blk, got.found, got.rank, got.retag, got.total);
          end else if (got.found) begin
            allocs_found++;
            if (got.rank != 0) fallbacks++;
            if (got.retag) retags++;
          end
        end
        rx_wait = $urandom_range(0, 6);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_tready <= !hold_off && (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic op_word_t rand_word();
    op_word_t w;
    int pick;
    w = 18'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) w.op = tfba_pkg::OP_ALLOC;
    else if (pick < 80) w.op = tfba_pkg::OP_FREE;
    else if (pick < 98) w.op = tfba_pkg::OP_ERASE;
    else w.op = tfba_pkg::OP_REINIT;
    if ($urandom_range(0, 19) != 0) w.hot = 2'($urandom_range(0, 2));
    return w;
  endfunction

  op_word_t dir_word[$];
  grant_t   dir_exp[$];
  bit       dir_chk[$];

  task automatic row(logic [1:0] op, logic [7:0] blk, logic [1:0] hot, logic wear,
                     logic [3:0] st, logic mp, bit chk, grant_t g);
    dir_word.push_back('{mapping: mp, stream: st, wear: wear, hot: hot, blk: blk, op: op});
    dir_chk.push_back(chk);
    dir_exp.push_back(g);
  endtask

  initial begin
    logic [8:0] settings[6][2];
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = tfba_pkg::CFG_HOT; cfg_data = '0;
    hold_off = 1'b0; mismatches = 0; grants_seen = 0; words_sent = 0;
    allocs_found = 0; fallbacks = 0; retags = 0; rx_wait = 0;
    hot_cnt = tfba_pkg::HotCountRst; warm_cnt = tfba_pkg::WarmCountRst;
    seed_pools();
    wait_cycles(5);
    rst_n <= 1'b1;
    wait_cycles(NBLK + 10);

    // After reset: block 0 is hot, block 51 warm, block 127 cold.
    row(tfba_pkg::OP_ALLOC, 8'd0, tfba_pkg::POOL_HOT, 0, 4'd15, 1, 1,
        '{total: 255, retag: 0, rank: 0, found: 1, blk: 0});
    row(tfba_pkg::OP_ALLOC, 8'd0, tfba_pkg::POOL_WARM, 0, 4'd0, 0, 1,
        '{total: 254, retag: 0, rank: 0, found: 1, blk: 51});
    row(tfba_pkg::OP_ALLOC, 8'd0, tfba_pkg::POOL_COLD, 0, 4'd7, 1, 1,
        '{total: 253, retag: 0, rank: 0, found: 1, blk: 127});
    row(tfba_pkg::OP_ALLOC, 8'd0, tfba_pkg::POOL_NONE, 1, 4'd3, 1, 1,
        '{total: 253, retag: 0, rank: 0, found: 0, blk: 0});
    row(tfba_pkg::OP_FREE, 8'd0, tfba_pkg::POOL_NONE, 0, 4'd0, 0, 1,
        '{total: 253, retag: 0, rank: 0, found: 0, blk: 0});
    row(tfba_pkg::OP_ERASE, 8'd255, tfba_pkg::POOL_NONE, 1, 4'd15, 1, 1,
        '{total: 253, retag: 0, rank: 0, found: 0, blk: 0});
    row(tfba_pkg::OP_ERASE, 8'd255, tfba_pkg::POOL_HOT, 0, 4'd0, 0, 0, '0);
    row(tfba_pkg::OP_FREE, 8'd255, tfba_pkg::POOL_HOT, 1, 4'd0, 0, 0, '0);
    row(tfba_pkg::OP_FREE, 8'd0, tfba_pkg::POOL_WARM, 1, 4'd0, 0, 0, '0);
    row(tfba_pkg::OP_FREE, 8'd51, tfba_pkg::POOL_COLD, 0, 4'd0, 0, 0, '0);
    row(tfba_pkg::OP_ALLOC, 8'd0, tfba_pkg::POOL_HOT, 0, 4'd1, 0, 0, '0);
    row(tfba_pkg::OP_REINIT, 8'd0, tfba_pkg::POOL_HOT, 0, 4'd0, 0, 1,
        '{total: 256, retag: 0, rank: 0, found: 0, blk: 0});
    foreach (dir_word[i]) begin
      if (dir_chk[i]) send_checked(dir_word[i], dir_exp[i]);
      else send_word(dir_word[i]);
    end
    drain();

    // Empty hot pool so fallbacks and retags happen early.
    write_reg(tfba_pkg::CFG_HOT, 9'd0);
    write_reg(tfba_pkg::CFG_WARM, 9'd2);
    send_checked('{mapping: 0, stream: 0, wear: 0, hot: tfba_pkg::POOL_HOT, blk: 0,
                   op: tfba_pkg::OP_REINIT},
                 '{total: 256, retag: 0, rank: 0, found: 0, blk: 0});
    send_checked('{mapping: 1, stream: 2, wear: 0, hot: tfba_pkg::POOL_HOT, blk: 0,
                   op: tfba_pkg::OP_ALLOC},
                 '{total: 255, retag: 1, rank: 1, found: 1, blk: 0});
    send_checked('{mapping: 0, stream: 2, wear: 0, hot: tfba_pkg::POOL_COLD, blk: 0,
                   op: tfba_pkg::OP_ALLOC},
                 '{total: 254, retag: 0, rank: 0, found: 1, blk: 2});
    drain();

    settings = '{'{9'd51, 9'd76}, '{9'd256, 9'd0}, '{9'd0, 9'd256},
                 '{9'd0, 9'd0}, '{9'd256, 9'd256}, '{9'd3, 9'd4}};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tfba_pkg::CFG_HOT, settings[ph][0]);
      write_reg(tfba_pkg::CFG_WARM, settings[ph][1]);
      send_word('{mapping: 0, stream: 0, wear: 0, hot: tfba_pkg::POOL_HOT, blk: 0,
                  op: tfba_pkg::OP_REINIT});
      for (int n = 0; n < 170; n++) begin
        if (ph == 2 && n == 60) fork
          begin hold_off = 1'b1; wait_cycles(1500); hold_off = 1'b0; end
        join_none
        send_word(rand_word());
      end
      drain();
    end

    $display("Sent %0d operation words across 8 seed settings; %0d results checked.",
             words_sent, grants_seen);
    $display("Grants: %0d, from a fallback pool %0d, retagged %0d.",
             allocs_found, fallbacks, retags);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_grants.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
